// File: rtl/tcf_pkg.sv
// Shared types and constants for the TCP connection engine.
// Used by every module under rtl; depends on nothing else.
package tcf_pkg;

    // Connection states as reported on conn_state_out.
    typedef enum logic [2:0] {
        ST_CLOSED    = 3'd0,
        ST_SYN_SENT  = 3'd1,
        ST_SYN_RCVD  = 3'd2,
        ST_ESTAB     = 3'd3,
        ST_FIN_WAIT1 = 3'd4,
        ST_FIN_WAIT2 = 3'd5,
        ST_TIME_WAIT = 3'd6,
        ST_LAST_ACK  = 3'd7
    } conn_state_t;

    // Event class of an item; a timer expiry is folded in as its own class.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_FIN_ACK = 3'd1,
        EV_SYN_ACK = 3'd2,
        EV_FIN     = 3'd3,
        EV_SYN     = 3'd4,
        EV_ACK     = 3'd5,
        EV_TIMER   = 3'd6
    } ev_class_t;

    typedef enum logic [1:0] {
        OC_REPLY = 2'd0,
        OC_QUIET = 2'd1,
        OC_SYNC  = 2'd2,
        OC_BAD   = 2'd3
    } outcome_t;

    localparam logic [7:0]  FL_FIN  = 8'h01;
    localparam logic [7:0]  FL_SYN  = 8'h02;
    localparam logic [7:0]  FL_ACK  = 8'h10;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Configuration port.
    localparam int          ADDR_W         = 3;
    localparam logic        REG_WINDOW     = 1'b0;
    localparam logic        REG_HEADER     = 1'b1;
    localparam logic [15:0] WINDOW_RESET   = 16'd8192;
    localparam logic [5:0]  HEADER_RESET   = 6'd20;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        ev_class_t   ev;
        logic [31:0] rx_seq;
        logic [31:0] rx_ack;
        logic [31:0] ack_next;
        logic [15:0] tick_low;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [15:0] tx_length;
    } tcf_item_t;

endpackage

// File: rtl/tcf_front.sv
// Front end: classifies an incoming item and precomputes its arithmetic.
// Depends on tcf_pkg.
module tcf_front
    import tcf_pkg::*;
(
    input  logic        mode,
    input  logic [7:0]  rx_flags,
    input  logic [31:0] rx_seq,
    input  logic [31:0] rx_ack,
    input  logic [15:0] rx_payload_len,
    input  logic [15:0] tx_payload_len,
    input  logic [15:0] rx_src_port,
    input  logic [15:0] rx_dst_port,
    input  logic [15:0] tick_low,
    input  logic [5:0]  header_bytes,
    output tcf_item_t   item
);

    logic        fin, syn, ack;
    logic [15:0] inc;
    logic [16:0] total;
    ev_class_t   ev;

    assign fin = rx_flags[0];
    assign syn = rx_flags[1];
    assign ack = rx_flags[4];

    // Priority: timer mode, FIN+ACK, SYN+ACK, FIN, SYN, ACK.
    always_comb begin
        priority if (mode)      ev = EV_TIMER;
        else if (fin && ack)    ev = EV_FIN_ACK;
        else if (syn && ack)    ev = EV_SYN_ACK;
        else if (fin)           ev = EV_FIN;
        else if (syn)           ev = EV_SYN;
        else if (ack)           ev = EV_ACK;
        else                    ev = EV_NONE;
    end

    // An empty segment still advances the acknowledgement by one.
    assign inc   = (rx_payload_len != 16'd0) ? rx_payload_len : 16'd1;
    assign total = {11'd0, header_bytes} + {1'b0, tx_payload_len};

    always_comb begin
        item.ev          = ev;
        item.rx_seq      = rx_seq;
        item.rx_ack      = rx_ack;
        item.ack_next    = rx_seq + {16'd0, inc};
        item.tick_low    = tick_low;
        item.remote_port = rx_src_port;
        item.local_port  = rx_dst_port;
        item.tx_length   = total[16] ? LEN_MAX : total[15:0];
    end

endmodule

// File: rtl/tcf_queue.sv
// Two-entry queue between the classifying front and the executing back.
// Depends on tcf_pkg for the item type.
module tcf_queue
    import tcf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  tcf_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output tcf_item_t rd_item
);

    tcf_item_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptrs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 || count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_ptrs_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with a single entry");

endmodule

// File: rtl/tcf_back.sv
// Back end: connection state machine, sequence state and result register.
// Depends on tcf_pkg.
module tcf_back
    import tcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  tcf_item_t   q_item,
    input  logic [15:0] window_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send,
    output logic [7:0]  m_tx_flags,
    output logic [31:0] m_tx_seq,
    output logic [31:0] m_tx_ack,
    output logic [15:0] m_tx_src_port,
    output logic [15:0] m_tx_dst_port,
    output logic [15:0] m_tx_window,
    output logic [15:0] m_tx_length,
    output logic [2:0]  m_conn_state_out,
    output logic        m_bad_event
);

    conn_state_t state_reg, state_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] ack_reg, ack_next;
    outcome_t    oc;
    logic [7:0]  txf;
    logic        bad;
    logic        fire;
    logic        valid_reg;

    logic        send_reg;
    logic [7:0]  flags_reg;
    logic [31:0] tseq_reg, tack_reg;
    logic [15:0] sport_reg, dport_reg, window_reg, length_reg;
    logic [2:0]  cstate_reg;
    logic        bad_reg;

    assign q_ready = !valid_reg || m_ready;
    assign fire    = q_valid && q_ready;

    // Next state.
    always_comb begin
        state_next = ST_CLOSED;
        if (q_item.ev == EV_NONE) begin
            state_next = state_reg;
        end else if (q_item.ev != EV_TIMER) begin
            unique case (state_reg)
                ST_CLOSED: begin
                    if (q_item.ev == EV_SYN) state_next = ST_SYN_RCVD;
                end
                ST_SYN_SENT: begin
                    if (q_item.ev == EV_SYN_ACK) state_next = ST_ESTAB;
                end
                ST_SYN_RCVD: begin
                    if (q_item.ev == EV_ACK) state_next = ST_ESTAB;
                end
                ST_ESTAB: begin
                    if (q_item.ev == EV_ACK) state_next = ST_ESTAB;
                    else if (q_item.ev == EV_FIN_ACK || q_item.ev == EV_FIN)
                        state_next = ST_LAST_ACK;
                end
                ST_FIN_WAIT1: begin
                    if (q_item.ev == EV_ACK) state_next = ST_FIN_WAIT2;
                    else if (q_item.ev == EV_FIN_ACK) state_next = ST_TIME_WAIT;
                end
                ST_FIN_WAIT2: begin
                    if (q_item.ev == EV_ACK) state_next = ST_FIN_WAIT2;
                    else if (q_item.ev == EV_FIN || q_item.ev == EV_FIN_ACK)
                        state_next = ST_TIME_WAIT;
                end
                ST_LAST_ACK: begin
                    if (q_item.ev == EV_ACK) state_next = ST_CLOSED;
                end
                default: state_next = ST_CLOSED;
            endcase
        end
    end

    // Outcome and reply flags.
    always_comb begin
        oc  = OC_BAD;
        txf = 8'd0;
        bad = 1'b0;
        if (q_item.ev == EV_NONE) begin
            oc = OC_QUIET;
        end else if (q_item.ev == EV_TIMER) begin
            oc  = OC_QUIET;
            bad = (state_reg != ST_TIME_WAIT);
        end else begin
            unique case (state_reg)
                ST_CLOSED: begin
                    if (q_item.ev == EV_SYN) begin
                        oc  = OC_REPLY;
                        txf = FL_SYN | FL_ACK;
                    end
                end
                ST_SYN_SENT: begin
                    if (q_item.ev == EV_SYN_ACK) begin
                        oc  = OC_REPLY;
                        txf = FL_ACK;
                    end
                end
                ST_SYN_RCVD: begin
                    if (q_item.ev == EV_ACK) oc = OC_SYNC;
                end
                ST_ESTAB: begin
                    if (q_item.ev == EV_ACK || q_item.ev == EV_FIN) begin
                        oc  = OC_REPLY;
                        txf = FL_ACK;
                    end else if (q_item.ev == EV_FIN_ACK) begin
                        oc  = OC_REPLY;
                        txf = FL_FIN | FL_ACK;
                    end
                end
                ST_FIN_WAIT1: begin
                    if (q_item.ev == EV_ACK) begin
                        oc = OC_QUIET;
                    end else if (q_item.ev == EV_FIN_ACK) begin
                        oc  = OC_REPLY;
                        txf = FL_ACK;
                    end
                end
                ST_FIN_WAIT2: begin
                    if (q_item.ev == EV_ACK) begin
                        oc = OC_QUIET;
                    end else if (q_item.ev == EV_FIN || q_item.ev == EV_FIN_ACK) begin
                        oc  = OC_REPLY;
                        txf = FL_ACK;
                    end
                end
                ST_LAST_ACK: begin
                    if (q_item.ev == EV_ACK) oc = OC_QUIET;
                end
                default: oc = OC_BAD;
            endcase
            bad = (oc == OC_BAD);
        end
    end

    // Sequence and acknowledgement updates.
    always_comb begin
        seq_next = seq_reg;
        ack_next = ack_reg;
        unique case (oc)
            OC_REPLY: begin
                seq_next = (state_reg == ST_CLOSED) ? {16'd0, q_item.tick_low}
                                                    : q_item.rx_ack;
                ack_next = q_item.ack_next;
            end
            OC_SYNC: begin
                seq_next = q_item.rx_ack;
                ack_next = q_item.rx_seq;
            end
            default: begin
                seq_next = seq_reg;
                ack_next = ack_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLOSED;
            seq_reg   <= 32'd0;
            ack_reg   <= 32'd0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
                seq_reg   <= seq_next;
                ack_reg   <= ack_next;
            end
            if (q_ready) begin
                valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            send_reg   <= (oc == OC_REPLY);
            cstate_reg <= state_next;
            bad_reg    <= bad;
            if (oc == OC_REPLY) begin
                flags_reg  <= txf;
                tseq_reg   <= seq_next;
                tack_reg   <= ack_next;
                sport_reg  <= q_item.local_port;
                dport_reg  <= q_item.remote_port;
                window_reg <= window_size;
                length_reg <= q_item.tx_length;
            end else begin
                flags_reg  <= 8'd0;
                tseq_reg   <= 32'd0;
                tack_reg   <= 32'd0;
                sport_reg  <= 16'd0;
                dport_reg  <= 16'd0;
                window_reg <= 16'd0;
                length_reg <= 16'd0;
            end
        end
    end

    assign m_valid          = valid_reg;
    assign m_send           = send_reg;
    assign m_tx_flags       = flags_reg;
    assign m_tx_seq         = tseq_reg;
    assign m_tx_ack         = tack_reg;
    assign m_tx_src_port    = sport_reg;
    assign m_tx_dst_port    = dport_reg;
    assign m_tx_window      = window_reg;
    assign m_tx_length      = length_reg;
    assign m_conn_state_out = cstate_reg;
    assign m_bad_event      = bad_reg;

    a_bad_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && bad_reg) |-> (cstate_reg == ST_CLOSED && !send_reg))
        else $error("bad event did not close the connection quietly");

    a_reply_acks: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && send_reg) |-> ((flags_reg & FL_ACK) == FL_ACK))
        else $error("reply without ACK flag");

    a_sync_estab: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && oc == OC_SYNC) |=> (state_reg == ST_ESTAB))
        else $error("handshake completion did not reach established");

    a_state_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (cstate_reg == state_reg))
        else $error("reported state differs from stored state");

endmodule

// File: rtl/tcp_connection_fsm_core.sv
// Two register stages, the queue entry and the result register, lie between an
// accepted input item and its result on the m_ outputs. Throughput: one item per
// cycle while m_ready is high; the two-entry queue and the result register let
// the input side accept up to two more items while a result waits on m_ready.
// Reset (aresetn low at a clock edge): connection closed, sequence and
// acknowledgement numbers zero, queue and result register empty, window 8192,
// header length 20.
module tcp_connection_fsm_core
    import tcf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    // Input item channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [7:0]        s_rx_flags,
    input  logic [31:0]       s_rx_seq,
    input  logic [31:0]       s_rx_ack,
    input  logic [15:0]       s_rx_payload_len,
    input  logic [15:0]       s_tx_payload_len,
    input  logic [15:0]       s_rx_src_port,
    input  logic [15:0]       s_rx_dst_port,
    input  logic [15:0]       s_tick_low,

    // Result item channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_send,
    output logic [7:0]        m_tx_flags,
    output logic [31:0]       m_tx_seq,
    output logic [31:0]       m_tx_ack,
    output logic [15:0]       m_tx_src_port,
    output logic [15:0]       m_tx_dst_port,
    output logic [15:0]       m_tx_window,
    output logic [15:0]       m_tx_length,
    output logic [2:0]        m_conn_state_out,
    output logic              m_bad_event
);

    // The registers are word-spaced, so only address bit 2 selects one of
    // them; the byte-offset bits are ignored, as is usual for this port.
    logic [15:0] window_reg;
    logic [5:0]  header_reg;
    logic        cfg_write;
    logic        reg_sel;

    tcf_item_t   front_item;
    tcf_item_t   back_item;
    logic        q_valid;
    logic        q_ready;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            header_reg <= HEADER_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_WINDOW: window_reg <= pwdata[15:0];
                REG_HEADER: header_reg <= pwdata[5:0];
                default:    window_reg <= window_reg;
            endcase
        end
    end

    // Read data is presented during the access cycle.
    always_comb begin
        unique case (reg_sel)
            REG_WINDOW: prdata = {16'd0, window_reg};
            REG_HEADER: prdata = {26'd0, header_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Front: the item is classified and its acknowledgement sum and reply
    // length are worked out before it is queued.
    tcf_front u_front (
        .mode           (s_mode),
        .rx_flags       (s_rx_flags),
        .rx_seq         (s_rx_seq),
        .rx_ack         (s_rx_ack),
        .rx_payload_len (s_rx_payload_len),
        .tx_payload_len (s_tx_payload_len),
        .rx_src_port    (s_rx_src_port),
        .rx_dst_port    (s_rx_dst_port),
        .tick_low       (s_tick_low),
        .header_bytes   (header_reg),
        .item           (front_item)
    );

    // The queue decouples the two halves, so the input is taken whenever
    // it has room, regardless of the result side.
    tcf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_item  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (back_item)
    );

    // Back: the state machine applies one item per cycle whenever the
    // result register is empty or being emptied.
    tcf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (back_item),
        .window_size      (window_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_send           (m_send),
        .m_tx_flags       (m_tx_flags),
        .m_tx_seq         (m_tx_seq),
        .m_tx_ack         (m_tx_ack),
        .m_tx_src_port    (m_tx_src_port),
        .m_tx_dst_port    (m_tx_dst_port),
        .m_tx_window      (m_tx_window),
        .m_tx_length      (m_tx_length),
        .m_conn_state_out (m_conn_state_out),
        .m_bad_event      (m_bad_event)
    );

endmodule
